@@ hdl/fdsc_pkg.sv @@
// ============================================================================
// fdsc_pkg
// Shared widths, register codes and reset values for the frame difference
// scene cut detector.
// ============================================================================
`default_nettype none

package fdsc_pkg;

  // Frame store geometry
  localparam int MAX_FRAME_PIXELS = 131072;
  localparam int ADDR_W           = $clog2(MAX_FRAME_PIXELS);
  localparam int LEN_W            = $clog2(MAX_FRAME_PIXELS + 1);

  // Payload widths
  localparam int PIXEL_W = 8;
  localparam int INDEX_W = 24;
  localparam int SUM_W   = 25;

  // Configuration widths
  localparam int THR_W      = 16;
  localparam int THR_FRAC   = 8;
  localparam int FP_W       = 18;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Threshold times frame length, and the width of the cut compare
  localparam int PROD_W = THR_W + LEN_W;
  localparam int LHS_W  = SUM_W + THR_FRAC;
  localparam int CUT_W  = (PROD_W > LHS_W) ? PROD_W : LHS_W;
  localparam int CMP_W  = (FP_W > LEN_W) ? FP_W : LEN_W;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register map
  localparam cfg_idx_t REG_THRESHOLD    = cfg_idx_t'(0);
  localparam cfg_idx_t REG_FRAME_PIXELS = cfg_idx_t'(1);

  // Reset values: threshold 30.0 in 8.8, 320x240 frame
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(7680);
  localparam logic [FP_W-1:0]  FP_RESET  = FP_W'(76800);

endpackage : fdsc_pkg

`default_nettype wire

@@ hdl/fdsc_pixel_if.sv @@
// ============================================================================
// fdsc_pixel_if
// Pixel stream channel: one first-channel pixel per beat.
// ============================================================================
`default_nettype none

interface fdsc_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [fdsc_pkg::PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface : fdsc_pixel_if

`default_nettype wire

@@ hdl/fdsc_result_if.sv @@
// ============================================================================
// fdsc_result_if
// Result channel: one frame comparison per beat.
// ============================================================================
`default_nettype none

interface fdsc_result_if;
  logic                         valid;
  logic                         ready;
  logic [fdsc_pkg::INDEX_W-1:0] frame_index;
  logic [fdsc_pkg::SUM_W-1:0]   diff_sum;
  logic                         scene_cut;

  modport source (output valid, output frame_index, output diff_sum, output scene_cut,
                  input ready);
  modport sink   (input valid, input frame_index, input diff_sum, input scene_cut,
                  output ready);
endinterface : fdsc_result_if

`default_nettype wire

@@ hdl/fdsc_cfg_if.sv @@
// ============================================================================
// fdsc_cfg_if
// Configuration write channel: register index and write data per beat.
// ============================================================================
`default_nettype none

interface fdsc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fdsc_pkg::CFG_IDX_W-1:0]  index;
  logic [fdsc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : fdsc_cfg_if

`default_nettype wire

@@ hdl/frame_difference_scene_cut.sv @@
// ============================================================================
// frame_difference_scene_cut
// Scene change detector: sums absolute pixel differences against the
// previous frame and flags a cut when the mean exceeds a threshold.
// ============================================================================
// The block takes one pixel per clock in raster order while not stalled. Each
// pixel enters a two-stage pipeline: in the first stage the frame store (one
// single-port RAM of MAX_FRAME_PIXELS x 8, read-first) returns the old pixel
// at this position and takes the new one in the same cycle; in the second
// stage the absolute difference is added to a saturating accumulator. At the
// last pixel of each frame after the first, one result goes from the second
// stage into an output register. The input side stalls only
// while a finished result is still waiting in that register and the next
// frame-closing pixel is ready to replace it. The first frame after reset
// only fills the store and yields no result; there is no clearing pass, so
// the block accepts pixels as soon as reset is released.
`default_nettype none

module frame_difference_scene_cut (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fdsc_pixel_if.sink  in_px,
  fdsc_result_if.source out_res,
  fdsc_cfg_if.sink    cfg_wr
);

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic first;
    logic last;
  } s1_ctl_t;

  logic [fdsc_pkg::THR_W-1:0]   thr_r;
  logic [fdsc_pkg::FP_W-1:0]    fp_r;
  logic [fdsc_pkg::PROD_W-1:0]  prod_r;
  logic [fdsc_pkg::CMP_W-1:0]   fp_ext;
  logic [fdsc_pkg::CMP_W-1:0]   len_ext;
  logic [fdsc_pkg::LEN_W-1:0]   len;

  logic [fdsc_pkg::ADDR_W-1:0]  pos_r;
  logic [fdsc_pkg::ADDR_W-1:0]  pos_nxt;
  logic                         first_r;
  logic                         first_nxt;
  logic                         last0;
  logic                         accept_in;
  logic                         stall;

  logic [fdsc_pkg::PIXEL_W-1:0] mem [fdsc_pkg::MAX_FRAME_PIXELS];
  logic [fdsc_pkg::PIXEL_W-1:0] old_px_r;

  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  logic [fdsc_pkg::PIXEL_W-1:0] s1_px_r;
  s1_ctl_t                      s1_ctl_r;
  logic                         s1_emit;
  logic                         s1_fire;

  logic [fdsc_pkg::PIXEL_W-1:0] diff;
  logic [fdsc_pkg::SUM_W:0]     sum_wide;
  logic [fdsc_pkg::SUM_W-1:0]   acc_sum;
  logic [fdsc_pkg::SUM_W-1:0]   acc_r;
  logic [fdsc_pkg::SUM_W-1:0]   acc_nxt;
  logic [fdsc_pkg::INDEX_W-1:0] frame_cnt_r;
  logic [fdsc_pkg::INDEX_W-1:0] frame_cnt_nxt;
  logic [fdsc_pkg::CUT_W-1:0]   lhs;
  logic [fdsc_pkg::CUT_W-1:0]   rhs;

  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [fdsc_pkg::INDEX_W-1:0] out_index_r;
  logic [fdsc_pkg::SUM_W-1:0]   out_sum_r;
  logic                         out_cut_r;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= fdsc_pkg::THR_RESET;
      fp_r  <= fdsc_pkg::FP_RESET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        fdsc_pkg::REG_THRESHOLD:    thr_r <= cfg_wr.data[fdsc_pkg::THR_W-1:0];
        fdsc_pkg::REG_FRAME_PIXELS: fp_r  <= cfg_wr.data[fdsc_pkg::FP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame length to 1..MAX_FRAME_PIXELS
  always_comb begin
    fp_ext = fdsc_pkg::CMP_W'(fp_r);
    if (fp_ext == '0) begin
      len_ext = fdsc_pkg::CMP_W'(1);
    end else if (fp_ext > fdsc_pkg::CMP_W'(fdsc_pkg::MAX_FRAME_PIXELS)) begin
      len_ext = fdsc_pkg::CMP_W'(fdsc_pkg::MAX_FRAME_PIXELS);
    end else begin
      len_ext = fp_ext;
    end
    len = len_ext[fdsc_pkg::LEN_W-1:0];
  end

  // Threshold x length; the user must move config only while idle, not enforced here
  always_ff @(posedge clk) begin
    prod_r <= fdsc_pkg::PROD_W'(thr_r) * fdsc_pkg::PROD_W'(len);
  end

  // --------------------------------------------------------------------------
  // Stage 0: position counter and frame store access
  // --------------------------------------------------------------------------
  assign in_px.ready = !stall;
  assign accept_in   = in_px.valid && !stall;
  assign last0       = (fdsc_pkg::LEN_W'(pos_r) + fdsc_pkg::LEN_W'(1)) >= len;

  always_comb begin
    pos_nxt   = pos_r;
    first_nxt = first_r;
    if (accept_in) begin
      if (last0) begin
        pos_nxt   = '0;
        first_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + fdsc_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      first_r <= 1'b1;
    end else begin
      pos_r   <= pos_nxt;
      first_r <= first_nxt;
    end
  end

  // Read the old pixel and write the new one at the same address
  always_ff @(posedge clk) begin
    if (accept_in) begin
      old_px_r   <= mem[pos_r];
      mem[pos_r] <= in_px.pixel;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: difference and accumulate
  // --------------------------------------------------------------------------
  assign s1_emit = s1_valid_r && s1_ctl_r.last && !s1_ctl_r.first;
  assign stall   = s1_emit && out_valid_r && !out_res.ready;
  assign s1_fire = s1_valid_r && !stall;

  // Hold the stage while its result cannot leave
  assign s1_valid_nxt = stall ? s1_valid_r : accept_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_px_r        <= in_px.pixel;
      s1_ctl_r.first <= first_r;
      s1_ctl_r.last  <= last0;
    end
  end

  // Absolute difference and saturating add
  always_comb begin
    if (s1_px_r > old_px_r) begin
      diff = s1_px_r - old_px_r;
    end else begin
      diff = old_px_r - s1_px_r;
    end
    sum_wide = {1'b0, acc_r} + (fdsc_pkg::SUM_W + 1)'(diff);
    if (sum_wide[fdsc_pkg::SUM_W]) begin
      acc_sum = '1;
    end else begin
      acc_sum = sum_wide[fdsc_pkg::SUM_W-1:0];
    end
  end

  // Mean test without division: sum * 256 > threshold * length
  assign lhs = fdsc_pkg::CUT_W'({acc_sum, {fdsc_pkg::THR_FRAC{1'b0}}});
  assign rhs = fdsc_pkg::CUT_W'(prod_r);

  always_comb begin
    acc_nxt       = acc_r;
    frame_cnt_nxt = frame_cnt_r;
    if (s1_fire) begin
      if (s1_ctl_r.last) begin
        acc_nxt = '0;
      end else if (!s1_ctl_r.first) begin
        acc_nxt = acc_sum;
      end
      if (s1_emit && (frame_cnt_r != '1)) begin
        frame_cnt_nxt = frame_cnt_r + fdsc_pkg::INDEX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      frame_cnt_r <= '0;
    end else begin
      acc_r       <= acc_nxt;
      frame_cnt_r <= frame_cnt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      out_index_r <= frame_cnt_r;
      out_sum_r   <= acc_sum;
      out_cut_r   <= (lhs > rhs);
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.frame_index = out_index_r;
  assign out_res.diff_sum    = out_sum_r;
  assign out_res.scene_cut   = out_cut_r;

endmodule : frame_difference_scene_cut

`default_nettype wire

@@ hdl/fdsc_checker.sv @@
// ============================================================================
// fdsc_checker
// Port-level checks on the result channel of the scene cut detector.
// ============================================================================
`default_nettype none

module fdsc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [fdsc_pkg::INDEX_W-1:0] out_frame_index,
  input wire logic [fdsc_pkg::SUM_W-1:0]   out_diff_sum,
  input wire logic                         out_scene_cut
);

  logic                         have_r;
  logic [fdsc_pkg::INDEX_W-1:0] last_idx_r;

  // Track the index of the last delivered beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r     <= 1'b0;
      last_idx_r <= '0;
    end else if (out_valid && out_ready) begin
      have_r     <= 1'b1;
      last_idx_r <= out_frame_index;
    end
  end

  // A pending result stays until taken
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_frame_index) && $stable(out_diff_sum)
      && $stable(out_scene_cut))
    else $error("result payload changed while stalled");

  // Frame indexes start at zero and count up by one until they saturate
  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |->
      (!have_r && (out_frame_index == '0)) ||
      (have_r && (out_frame_index == last_idx_r + fdsc_pkg::INDEX_W'(1))) ||
      (have_r && (last_idx_r == '1) && (out_frame_index == '1)))
    else $error("frame index out of sequence");

  // A cut needs a nonzero difference sum
  a_cut_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scene_cut |-> out_diff_sum != '0)
    else $error("scene cut flagged with zero difference");

endmodule : fdsc_checker

bind frame_difference_scene_cut fdsc_checker u_fdsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_frame_index (out_res.frame_index),
  .out_diff_sum    (out_res.diff_sum),
  .out_scene_cut   (out_res.scene_cut)
);

`default_nettype wire

@@ tb/sv/frame_difference_scene_cut_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// frame_difference_scene_cut_tb
// Self-checking bench for the frame difference scene cut detector. The bench
// tracks the expected per-frame difference sums and cut flags at the pixel
// beats it sees accepted. It fills the frame store with one frame of the
// longest length used, runs short directed frames, then random frames of
// random length with random stalls on both channels and one long output
// hold-off.
// ============================================================================

module frame_difference_scene_cut_tb;
  import fdsc_pkg::*;

  localparam int unsigned SUM_MAX       = (1 << SUM_W) - 1;
  localparam int unsigned INDEX_MAX     = (1 << INDEX_W) - 1;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 200;
  localparam int          RANDOM_ITEMS  = 350;
  localparam int          FILL_LEN      = 300;
  localparam int          CYCLE_LIMIT   = 4000000;

  typedef struct packed {
    logic [INDEX_W-1:0] frame_index;
    logic [SUM_W-1:0]   diff_sum;
    logic               scene_cut;
  } frame_result_t;

  typedef struct packed {
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk;
  logic rst_n;

  fdsc_pixel_if  px_if ();
  fdsc_result_if res_if ();
  fdsc_cfg_if    cfg_if ();

  frame_difference_scene_cut dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_px   (px_if),
    .out_res (res_if),
    .cfg_wr  (cfg_if)
  );

  // Stimulus backlogs and expected frame results
  logic [PIXEL_W-1:0] pixel_backlog [$];
  reg_write_t         cfg_backlog [$];
  frame_result_t      pending_results [$];

  // Mirror of the detector state
  logic [PIXEL_W-1:0] scene_store [0:MAX_FRAME_PIXELS-1];
  int unsigned        scan_pos;
  int unsigned        abs_diff_total;
  int unsigned        pairs_compared;
  logic               filling_first;
  int unsigned        cut_threshold;
  int unsigned        frame_len_reg;

  int unsigned err_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          px_gap;
  int          cfg_gap;
  int          res_stall;
  logic        hold_arm;
  logic        hold_on;
  int          hold_count;
  int          cycle_count;

  always #1 clk = ~clk;

  function automatic int idle_draw(input int pct);
    if ($urandom_range(0, 99) < pct) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic int idle_pct_pick();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 25;
      default: return 60;
    endcase
  endfunction

  // Append one pixel to the stimulus backlog
  task automatic queue_pixel(input logic [PIXEL_W-1:0] px);
    pixel_backlog = {pixel_backlog, px};
  endtask

  // Append one expected result
  task automatic queue_result(input frame_result_t res);
    pending_results = {pending_results, res};
  endtask

  // Advance the mirror by one accepted pixel
  task automatic track_pixel(input logic [PIXEL_W-1:0] px);
    int unsigned      len;
    int unsigned      old;
    longint unsigned  lhs;
    longint unsigned  rhs;
    frame_result_t    res;
    len = frame_len_reg;
    if (len < 1) len = 1;
    if (len > MAX_FRAME_PIXELS) len = MAX_FRAME_PIXELS;
    if (!filling_first) begin
      old = 32'(scene_store[scan_pos]);
      abs_diff_total = abs_diff_total + ((px > old) ? (px - old) : (old - px));
      if (abs_diff_total > SUM_MAX) abs_diff_total = SUM_MAX;
    end
    scene_store[scan_pos] = px;
    if (scan_pos + 1 >= len) begin
      if (filling_first) begin
        filling_first = 1'b0;
      end else begin
        lhs = 64'(abs_diff_total) << THR_FRAC;
        rhs = 64'(cut_threshold) * 64'(len);
        res.frame_index = INDEX_W'(pairs_compared);
        res.diff_sum    = SUM_W'(abs_diff_total);
        res.scene_cut   = (lhs > rhs);
        queue_result(res);
        if (pairs_compared < INDEX_MAX) pairs_compared++;
      end
      abs_diff_total = 0;
      scan_pos       = 0;
    end else begin
      scan_pos++;
    end
  endtask

  // Pixel driver: track each accepted beat, then wait out a gap or offer the next
  always @(posedge clk) begin : pixel_driver
    logic nvalid;
    nvalid = px_if.valid;
    if (px_if.valid && px_if.ready) begin
      track_pixel(px_if.pixel);
      px_gap = idle_draw(send_idle_pct);
      nvalid = 1'b0;
    end
    if (!nvalid) begin
      if (px_gap > 0) begin
        px_gap--;
      end else if (pixel_backlog.size() > 0) begin
        nvalid = 1'b1;
        px_if.pixel <= pixel_backlog.pop_front();
      end
    end
    px_if.valid <= nvalid;
  end

  // Register write driver: apply each accepted write to the mirror
  always @(posedge clk) begin : cfg_driver
    logic   nvalid;
    reg_write_t wr;
    nvalid = cfg_if.valid;
    if (cfg_if.valid && cfg_if.ready) begin
      if (cfg_if.index == REG_THRESHOLD) begin
        cut_threshold = 32'(cfg_if.data[THR_W-1:0]);
      end else if (cfg_if.index == REG_FRAME_PIXELS) begin
        frame_len_reg = 32'(cfg_if.data[FP_W-1:0]);
      end
      cfg_gap = idle_draw(send_idle_pct);
      nvalid  = 1'b0;
    end
    if (!nvalid) begin
      if (cfg_gap > 0) begin
        cfg_gap--;
      end else if (cfg_backlog.size() > 0) begin
        nvalid = 1'b1;
        wr = cfg_backlog.pop_front();
        cfg_if.index <= wr.idx;
        cfg_if.data  <= wr.data;
      end
    end
    cfg_if.valid <= nvalid;
  end

  // Result monitor: compare each beat with the oldest expectation, then stall
  always @(posedge clk) begin : result_monitor
    frame_result_t exp_res;
    if (res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: frame_index %0d diff_sum %0d scene_cut %0d",
               res_if.frame_index, res_if.diff_sum, res_if.scene_cut);
        err_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (res_if.frame_index !== exp_res.frame_index) begin
          $error("frame_index: expected %0d, got %0d", exp_res.frame_index,
                 res_if.frame_index);
          err_count++;
        end
        if (res_if.diff_sum !== exp_res.diff_sum) begin
          $error("diff_sum: expected %0d, got %0d", exp_res.diff_sum, res_if.diff_sum);
          err_count++;
        end
        if (res_if.scene_cut !== exp_res.scene_cut) begin
          $error("scene_cut: expected %0d, got %0d", exp_res.scene_cut,
                 res_if.scene_cut);
          err_count++;
        end
      end
      res_stall = idle_draw(recv_idle_pct);
    end else if (res_stall > 0) begin
      res_stall--;
    end
    res_if.ready <= (res_stall == 0) && !hold_on;
  end

  // Long output hold-off, counted once it is armed
  always @(posedge clk) begin : hold_timer
    if (hold_arm && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      hold_on    <= 1'b1;
    end else begin
      hold_on <= 1'b0;
    end
  end

  // Run limit
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
    reg_write_t wr;
    wr.idx  = idx;
    wr.data = CFG_DATA_W'(value);
    cfg_backlog = {cfg_backlog, wr};
  endtask

  // Hold until every beat is out and every expected result has come back
  task automatic settle();
    while (pixel_backlog.size() != 0 || cfg_backlog.size() != 0 || px_if.valid ||
           cfg_if.valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int                 random_items;
    int                 count;
    int                 gen_len;
    int                 fp;
    int                 thr;
    bit                 noisy;
    logic [PIXEL_W-1:0] scene_base;
    logic [PIXEL_W-1:0] seq_px [$];

    clk            = 1'b0;
    rst_n          = 1'b0;
    px_if.valid    = 1'b0;
    px_if.pixel    = '0;
    res_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    scan_pos       = 0;
    abs_diff_total = 0;
    pairs_compared = 0;
    filling_first  = 1'b1;
    cut_threshold  = 32'(THR_RESET);
    frame_len_reg  = 32'(FP_RESET);
    err_count      = 0;
    send_idle_pct  = 5;
    recv_idle_pct  = 5;
    px_gap         = 0;
    cfg_gap        = 0;
    res_stall      = 0;
    hold_arm       = 1'b0;
    hold_on        = 1'b0;
    hold_count     = 0;
    cycle_count    = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the store at the longest frame length used later, then a white
    // frame over the black one gives a full-scale sum above the reset threshold
    write_reg(REG_FRAME_PIXELS, FILL_LEN);
    settle();
    for (int i = 0; i < FILL_LEN; i++) queue_pixel(8'h00);
    for (int i = 0; i < FILL_LEN; i++) queue_pixel(8'hFF);
    settle();

    // Zero length clamps to one pixel per frame; zero threshold cuts on any change
    send_idle_pct = 30;
    recv_idle_pct = 30;
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_FRAME_PIXELS, 0);
    settle();
    seq_px = {8'h00, 8'hFF, 8'hFF, 8'h55, 8'hAA, 8'h00};
    foreach (seq_px[i]) queue_pixel(seq_px[i]);
    settle();

    // Top threshold never cuts, even on a full-scale change
    write_reg(REG_THRESHOLD, (1 << THR_W) - 1);
    write_reg(REG_FRAME_PIXELS, 1);
    settle();
    queue_pixel(8'hFF);
    queue_pixel(8'h00);
    settle();

    // Mean of exactly 1.0 is not a cut; just under and just over around it
    write_reg(REG_THRESHOLD, 256);
    write_reg(REG_FRAME_PIXELS, 4);
    settle();
    seq_px = {8'd10, 8'd20, 8'd30, 8'd40, 8'd11, 8'd21, 8'd31, 8'd41,
              8'd10, 8'd20, 8'd30, 8'd41, 8'd15, 8'd20, 8'd30, 8'd41};
    foreach (seq_px[i]) queue_pixel(seq_px[i]);
    settle();

    // Hold the output off while single-pixel frames keep coming, so the input stalls
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_FRAME_PIXELS, 1);
    settle();
    hold_arm = 1'b1;
    for (int i = 0; i < 40; i++) queue_pixel(PIXEL_W'($urandom_range(0, 255)));
    settle();

    // Random frames; item counts leave frames open across length changes
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      send_idle_pct = idle_pct_pick();
      recv_idle_pct = idle_pct_pick();
      case ($urandom_range(0, 4))
        0:       thr = 0;
        1:       thr = (1 << THR_W) - 1;
        2:       thr = $urandom_range(0, (1 << THR_W) - 1);
        default: thr = $urandom_range(0, 100 * 256);
      endcase
      case ($urandom_range(0, 9))
        0:       fp = 0;
        1:       fp = 1;
        2:       fp = $urandom_range(2, 4);
        8:       fp = $urandom_range(41, FILL_LEN);
        default: fp = $urandom_range(5, 40);
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(REG_THRESHOLD, thr);
      write_reg(REG_FRAME_PIXELS, fp);
      settle();
      gen_len    = (fp == 0) ? 1 : fp;
      count      = $urandom_range(10, 90);
      noisy      = ($urandom_range(0, 2) != 0);
      scene_base = PIXEL_W'($urandom_range(0, 255));
      for (int k = 0; k < count; k++) begin
        if (!noisy) begin
          queue_pixel(PIXEL_W'($urandom_range(0, 255)));
        end else begin
          // Steady scene with sensor noise, and a cut now and then
          if (k % gen_len == 0 && $urandom_range(0, 3) == 0) begin
            scene_base = PIXEL_W'($urandom_range(0, 255));
          end
          queue_pixel(scene_base + PIXEL_W'((k % gen_len) * 3)
                      + PIXEL_W'($urandom_range(0, 2)));
        end
      end
      random_items += count;
      settle();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : frame_difference_scene_cut_tb

@@ filelist.f @@
hdl/fdsc_pkg.sv
hdl/fdsc_pixel_if.sv
hdl/fdsc_result_if.sv
hdl/fdsc_cfg_if.sv
hdl/frame_difference_scene_cut.sv
hdl/fdsc_checker.sv
tb/sv/frame_difference_scene_cut_tb.sv
